/* hw/rtl/quicksort_pivot_select_core_assert.svh */
// assertion macros shared by the checker
`ifndef QUICKSORT_PIVOT_SELECT_CORE_ASSERT_SVH
`define QUICKSORT_PIVOT_SELECT_CORE_ASSERT_SVH

`define QPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define QPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/qps_pkg.sv */
package qps_pkg;

    localparam int unsigned MaxElements = 64;
    localparam int unsigned DataW = 32;
    localparam int unsigned CountW = 11;
    localparam logic [15:0] LfsrTaps = 16'hB400;

    typedef enum logic [2:0] {
        PIV_FIRST  = 3'd0,
        PIV_LAST   = 3'd1,
        PIV_MIDDLE = 3'd2,
        PIV_RANDOM = 3'd3,
        PIV_MEDIAN = 3'd4
    } pivot_mode_t;

    typedef enum logic [0:0] {
        CFG_PIVOT_MODE  = 1'b0,
        CFG_RANDOM_SEED = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [DataW-1:0] value;
        logic                    last_item;
    } in_item_t;

    typedef struct packed {
        logic signed [DataW-1:0] sorted_value;
        logic                    last_out;
        logic [CountW-1:0]       comparison_count;
        logic                    overflow;
    } out_item_t;

    // controller state
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_SEG,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_MED,
        ST_RND,
        ST_PSWAP_RD,
        ST_PSWAP_WR,
        ST_PSWAP_WR2,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_SWAP_WR2,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_FIN_WR2,
        ST_PUSH_R,
        ST_PUSH_L,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_STORE,
        OP_INIT,
        OP_POP,
        OP_SEG,
        OP_RD_LO,
        OP_RD_MID,
        OP_RD_HI,
        OP_MED,
        OP_RND,
        OP_PSW_RD,
        OP_PSW_WR,
        OP_PSW_WR2,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_SW_RD,
        OP_SW_WR,
        OP_SW_WR2,
        OP_FIN_RD,
        OP_FIN_WR,
        OP_FIN_WR2,
        OP_PUSH_R,
        OP_PUSH_L,
        OP_OUT_RD,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } qps_cmd_t;

    typedef struct packed {
        logic last_load;     // load carried last flag
        logic multi;         // more than one element
        logic stack_empty;
        logic scan_done;     // j passed hi
        logic is_less;       // scanned element below pivot
        logic push_r;
        logic push_l;
        logic out_last;
        logic rnd_mode;      // random pivot selected
        logic rnd_done;      // remainder on its last bit
    } qps_status_t;

endpackage

/* hw/rtl/qps_ctrl.sv */
module qps_ctrl
    import qps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  qps_status_t status,
    output logic        busy,
    output qps_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:      if (start) state_next = ST_INIT;
            ST_INIT:
            begin
                if (!status.last_load) state_next = ST_LOAD;
                else if (status.multi) state_next = ST_POP;
                else state_next = ST_OUT_RD;
            end
            ST_POP:       state_next = status.stack_empty ? ST_OUT_RD : ST_POP_WAIT;
            ST_POP_WAIT:  state_next = ST_SEG;
            ST_SEG:       state_next = ST_RD_A;
            ST_RD_A:      state_next = ST_RD_B;
            ST_RD_B:      state_next = ST_RD_C;
            ST_RD_C:      state_next = ST_MED;
            ST_MED:       state_next = status.rnd_mode ? ST_RND : ST_PSWAP_RD;
            ST_RND:       state_next = status.rnd_done ? ST_PSWAP_RD : ST_RND;
            ST_PSWAP_RD:  state_next = ST_PSWAP_WR;
            ST_PSWAP_WR:  state_next = ST_PSWAP_WR2;
            ST_PSWAP_WR2: state_next = ST_SCAN_RD;
            ST_SCAN_RD:   state_next = status.scan_done ? ST_FIN_RD : ST_SCAN_CMP;
            ST_SCAN_CMP:  state_next = status.is_less ? ST_SWAP_RD : ST_SCAN_RD;
            ST_SWAP_RD:   state_next = ST_SWAP_WR;
            ST_SWAP_WR:   state_next = ST_SWAP_WR2;
            ST_SWAP_WR2:  state_next = ST_SCAN_RD;
            ST_FIN_RD:    state_next = ST_FIN_WR;
            ST_FIN_WR:    state_next = ST_FIN_WR2;
            ST_FIN_WR2:   state_next = ST_PUSH_R;
            ST_PUSH_R:    state_next = ST_PUSH_L;
            ST_PUSH_L:    state_next = ST_POP;
            ST_OUT_RD:    state_next = ST_OUT;
            ST_OUT:       state_next = status.out_last ? ST_LOAD : ST_OUT;
            default:      state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        busy   = (state_reg != ST_LOAD);
        cmd.op = OP_NONE;
        case (state_reg)
            ST_LOAD:      cmd.op = start ? OP_STORE : OP_NONE;
            ST_INIT:      cmd.op = OP_INIT;
            ST_POP:       cmd.op = OP_POP;
            ST_POP_WAIT:  cmd.op = OP_NONE;
            ST_SEG:       cmd.op = OP_SEG;
            ST_RD_A:      cmd.op = OP_RD_LO;
            ST_RD_B:      cmd.op = OP_RD_MID;
            ST_RD_C:      cmd.op = OP_RD_HI;
            ST_MED:       cmd.op = OP_MED;
            ST_RND:       cmd.op = OP_RND;
            ST_PSWAP_RD:  cmd.op = OP_PSW_RD;
            ST_PSWAP_WR:  cmd.op = OP_PSW_WR;
            ST_PSWAP_WR2: cmd.op = OP_PSW_WR2;
            ST_SCAN_RD:   cmd.op = OP_SCAN_RD;
            ST_SCAN_CMP:  cmd.op = OP_SCAN_CMP;
            ST_SWAP_RD:   cmd.op = OP_SW_RD;
            ST_SWAP_WR:   cmd.op = OP_SW_WR;
            ST_SWAP_WR2:  cmd.op = OP_SW_WR2;
            ST_FIN_RD:    cmd.op = OP_FIN_RD;
            ST_FIN_WR:    cmd.op = OP_FIN_WR;
            ST_FIN_WR2:   cmd.op = OP_FIN_WR2;
            ST_PUSH_R:    cmd.op = OP_PUSH_R;
            ST_PUSH_L:    cmd.op = OP_PUSH_L;
            ST_OUT_RD:    cmd.op = OP_OUT_RD;
            ST_OUT:       cmd.op = OP_OUT;
            default:      cmd.op = OP_NONE;
        endcase
    end

endmodule

/* hw/rtl/qps_datapath.sv */
module qps_datapath
    import qps_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = MaxElements
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  qps_cmd_t    cmd,
    input  in_item_t    in_item,
    input  logic        cfg_valid,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output qps_status_t status,
    output logic        result_valid,
    output out_item_t   result
);

    localparam int unsigned IdxW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CntW = IdxW + 1;

    // element store and segment stack
    logic [DataW-1:0]  mem [MAX_ELEMENTS];
    logic [2*IdxW-1:0] stk [MAX_ELEMENTS];

    logic [DataW-1:0]  rd_data_reg;
    logic [2*IdxW-1:0] stk_rd_reg;

    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   sp_reg;
    logic [CountW-1:0] cmp_reg;
    logic              ovf_reg;
    logic              last_reg;
    logic [2:0]        mode_reg;
    logic [15:0]       lfsr_reg;

    logic [IdxW-1:0]   lo_reg;
    logic [IdxW-1:0]   hi_reg;
    logic [IdxW-1:0]   mid_reg;
    logic [IdxW-1:0]   piv_reg;
    logic [IdxW:0]     i_reg;
    logic [IdxW:0]     j_reg;
    logic [DataW-1:0]  pv_reg;
    logic [DataW-1:0]  a_reg;
    logic [DataW-1:0]  b_reg;
    logic [DataW-1:0]  tmp_reg;
    logic [IdxW-1:0]   out_reg;
    logic [IdxW:0]     rnd_rem_reg;
    logic [3:0]        rnd_cnt_reg;

    // memory port control
    logic              we;
    logic [IdxW-1:0]   waddr;
    logic [DataW-1:0]  wdata;
    logic [IdxW-1:0]   raddr;
    logic              s_we;
    logic [IdxW-1:0]   s_waddr;
    logic [2*IdxW-1:0] s_wdata;

    logic [15:0]       lfsr_adv;
    logic [IdxW:0]     seg_len;
    logic [IdxW:0]     rnd_shift;
    logic [IdxW:0]     rnd_rem_next;
    logic [IdxW-1:0]   med_sel;
    logic [IdxW:0]     pm1;

    function automatic logic slt(input logic [DataW-1:0] x, input logic [DataW-1:0] y);
        slt = $signed(x) < $signed(y);
    endfunction

    assign lfsr_adv = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LfsrTaps) : (lfsr_reg >> 1);
    assign seg_len  = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;

    // lfsr modulo segment length, one dividend bit per cycle, msb first
    assign rnd_shift    = {rnd_rem_reg[IdxW-1:0], lfsr_reg[rnd_cnt_reg]};
    assign rnd_rem_next = (rnd_shift >= seg_len) ? (rnd_shift - seg_len) : rnd_shift;

    // third sample (hi) is still on the read port
    always_comb
    begin
        if (slt(b_reg, a_reg) != slt(rd_data_reg, a_reg))
            med_sel = lo_reg;
        else if (slt(a_reg, b_reg) != slt(rd_data_reg, b_reg))
            med_sel = mid_reg;
        else
            med_sel = hi_reg;
    end

    assign pm1 = i_reg - 1'b1;

    always_comb
    begin
        we      = 1'b0;
        waddr   = '0;
        wdata   = tmp_reg;
        raddr   = '0;
        s_we    = 1'b0;
        s_waddr = sp_reg[IdxW-1:0];
        s_wdata = '0;
        case (cmd.op)
            OP_STORE:
            begin
                we    = (count_reg < CntW'(MAX_ELEMENTS));
                waddr = count_reg[IdxW-1:0];
                wdata = in_item.value;
            end
            OP_INIT:
            begin
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = {{IdxW{1'b0}}, IdxW'(count_reg - 1'b1)};
            end
            OP_RD_LO:    raddr = lo_reg;
            OP_RD_MID:   raddr = mid_reg;
            OP_RD_HI:    raddr = hi_reg;
            OP_PSW_RD:   raddr = lo_reg;
            OP_PSW_WR:
            begin
                we    = 1'b1;
                waddr = lo_reg;
                wdata = pv_reg;
            end
            OP_PSW_WR2:
            begin
                we    = 1'b1;
                waddr = piv_reg;
                wdata = tmp_reg;
            end
            OP_SCAN_RD:  raddr = j_reg[IdxW-1:0];
            OP_SW_RD:    raddr = i_reg[IdxW-1:0];
            OP_SW_WR:
            begin
                we    = 1'b1;
                waddr = i_reg[IdxW-1:0];
                wdata = a_reg;
            end
            OP_SW_WR2:
            begin
                we    = 1'b1;
                waddr = j_reg[IdxW-1:0];
                wdata = tmp_reg;
            end
            OP_FIN_RD:   raddr = pm1[IdxW-1:0];
            OP_FIN_WR:
            begin
                we    = 1'b1;
                waddr = lo_reg;
                wdata = rd_data_reg;
            end
            OP_FIN_WR2:
            begin
                we    = 1'b1;
                waddr = pm1[IdxW-1:0];
                wdata = pv_reg;
            end
            OP_PUSH_R:
            begin
                s_we    = (pm1 + 1'b1 < {1'b0, hi_reg});
                s_wdata = {IdxW'(pm1 + 1'b1), hi_reg};
            end
            OP_PUSH_L:
            begin
                s_we    = (pm1 > {1'b0, lo_reg} + 1'b1);
                s_wdata = {lo_reg, IdxW'(pm1 - 1'b1)};
            end
            OP_OUT_RD:   raddr = '0;
            OP_OUT:      raddr = out_reg + 1'b1;
            default:     raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
        // pivot index is settled by now
        if (cmd.op == OP_PSW_RD)
        begin
            pv_reg <= mem[piv_reg];
        end
        if (s_we)
        begin
            stk[s_waddr] <= s_wdata;
        end
        if (cmd.op == OP_POP)
        begin
            stk_rd_reg <= stk[IdxW'(sp_reg - 1'b1)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sp_reg    <= '0;
            cmp_reg   <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
            mode_reg  <= PIV_FIRST;
            lfsr_reg  <= 16'd1;
            out_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PIVOT_MODE:  mode_reg <= cfg_data[2:0];
                    CFG_RANDOM_SEED: lfsr_reg <= (cfg_data == '0) ? 16'd1 : cfg_data;
                    default:         mode_reg <= mode_reg;
                endcase
            end
            case (cmd.op)
                OP_STORE:
                begin
                    last_reg <= in_item.last_item;
                    if (count_reg < CntW'(MAX_ELEMENTS))
                        count_reg <= count_reg + 1'b1;
                    else
                        ovf_reg <= 1'b1;
                end
                OP_INIT:
                begin
                    cmp_reg <= '0;
                    sp_reg  <= (count_reg > 1) ? CntW'(1) : '0;
                end
                OP_POP:
                begin
                    if (sp_reg != '0)
                        sp_reg <= sp_reg - 1'b1;
                end
                OP_MED:
                begin
                    if (mode_reg == PIV_RANDOM)
                        lfsr_reg <= lfsr_adv;
                end
                OP_SCAN_RD:
                begin
                    if (j_reg <= {1'b0, hi_reg})
                        cmp_reg <= cmp_reg + 1'b1;
                end
                OP_PUSH_R, OP_PUSH_L:
                begin
                    if (s_we)
                        sp_reg <= sp_reg + 1'b1;
                end
                OP_OUT_RD:   out_reg <= '0;
                OP_OUT:
                begin
                    out_reg <= out_reg + 1'b1;
                    if (out_reg == IdxW'(count_reg - 1'b1))
                    begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        sp_reg    <= '0;
                    end
                end
                default:     out_reg <= out_reg;
            endcase
        end
    end

    // partition working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SEG:
            begin
                lo_reg  <= stk_rd_reg[2*IdxW-1:IdxW];
                hi_reg  <= stk_rd_reg[IdxW-1:0];
                mid_reg <= IdxW'(({1'b0, stk_rd_reg[2*IdxW-1:IdxW]}
                           + {1'b0, stk_rd_reg[IdxW-1:0]}) >> 1);
            end
            OP_RD_MID:   a_reg <= rd_data_reg;
            OP_RD_HI:    b_reg <= rd_data_reg;
            OP_MED:
            begin
                rnd_rem_reg <= '0;
                rnd_cnt_reg <= 4'd15;
                case (mode_reg)
                    PIV_LAST:   piv_reg <= hi_reg;
                    PIV_MIDDLE: piv_reg <= mid_reg;
                    PIV_MEDIAN: piv_reg <= med_sel;
                    default:    piv_reg <= lo_reg;
                endcase
            end
            OP_RND:
            begin
                rnd_rem_reg <= rnd_rem_next;
                rnd_cnt_reg <= rnd_cnt_reg - 1'b1;
                if (rnd_cnt_reg == 4'd0)
                    piv_reg <= IdxW'({1'b0, lo_reg} + rnd_rem_next);
            end
            OP_PSW_WR:
            begin
                tmp_reg <= rd_data_reg;
            end
            OP_PSW_WR2:
            begin
                i_reg <= {1'b0, lo_reg} + 1'b1;
                j_reg <= {1'b0, lo_reg} + 1'b1;
            end
            OP_SCAN_CMP:
            begin
                a_reg <= rd_data_reg;
                if (!slt(rd_data_reg, pv_reg))
                    j_reg <= j_reg + 1'b1;
            end
            OP_SW_WR:    tmp_reg <= rd_data_reg;
            OP_SW_WR2:
            begin
                i_reg <= i_reg + 1'b1;
                j_reg <= j_reg + 1'b1;
            end
            OP_FIN_WR:   tmp_reg <= rd_data_reg;
            default:     tmp_reg <= tmp_reg;
        endcase
    end

    assign status.last_load   = last_reg;
    assign status.multi       = (count_reg > 1);
    assign status.stack_empty = (sp_reg == '0);
    assign status.scan_done   = (j_reg > {1'b0, hi_reg});
    assign status.is_less     = slt(rd_data_reg, pv_reg);
    assign status.push_r      = (pm1 + 1'b1 < {1'b0, hi_reg});
    assign status.push_l      = (pm1 > {1'b0, lo_reg} + 1'b1);
    assign status.out_last    = (out_reg == IdxW'(count_reg - 1'b1));
    assign status.rnd_mode    = (mode_reg == PIV_RANDOM);
    assign status.rnd_done    = (rnd_cnt_reg == 4'd0);

    assign result_valid            = (cmd.op == OP_OUT);
    assign result.sorted_value     = rd_data_reg;
    assign result.last_out         = status.out_last;
    assign result.comparison_count = cmp_reg;
    assign result.overflow         = ovf_reg;

endmodule

/* hw/rtl/quicksort_pivot_select_core.sv */
// channel   signals                              transaction when
// input     start, busy, in_item                 start && !busy
// result    result_valid, result                 result_valid (no stall)
// config    cfg_valid, cfg_ready, cfg_index/data cfg_valid && cfg_ready
// a non-final load passes through the load and init states back to load; the final one starts the sort
// each segment steps through pop, pivot choice, pivot swap and pushes
// a random pivot adds a modulo step, one remainder bit per cycle
// each compared element is read and compared, then swapped forward when below the pivot
// sorted values then stream one per cycle, result_valid marking each
// reset clears counts and control; store contents stay undefined
module quicksort_pivot_select_core
    import qps_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = MaxElements
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    in_item,
    output logic        result_valid,
    output out_item_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    qps_cmd_t    cmd;
    qps_status_t status;

    assign cfg_ready = 1'b1;

    qps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    qps_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_item      (in_item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* hw/rtl/qps_checker.sv */
`include "quicksort_pivot_select_core_assert.svh"

module qps_checker
    import qps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      result_valid,
    input out_item_t result
);

    // a results burst only runs while busy
    `QPS_ASSERT_IMPL(a_res_busy, result_valid, busy, "result outside busy window")

    // an accepted load makes the block busy
    `QPS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "load not taken")

    // the final result ends the run
    `QPS_ASSERT_NEXT(a_last_idle, result_valid && result.last_out, !busy,
        "busy after final result")

endmodule

bind quicksort_pivot_select_core qps_checker u_qps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

/* sim/quicksort_pivot_select_core_tb.sv */
module quicksort_pivot_select_core_tb;
    import qps_pkg::*;

    localparam int unsigned Capacity = 64;
    localparam int unsigned StallLimit = 40000;
    localparam int unsigned TargetItems = 470;

    class sort_scoreboard;
        logic signed [31:0] store [Capacity];
        int unsigned        count;
        bit                 dropped;
        logic [2:0]         mode;
        logic [15:0]        lfsr;
        logic [10:0]        compares;
        out_item_t          sorted_q [$];
        int unsigned        errors;

        function new();
            count = 0;
            dropped = 0;
            mode = PIV_FIRST;
            lfsr = 16'd1;
            compares = '0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(cfg_index_t idx, logic [15:0] data);
            if (idx == CFG_PIVOT_MODE)
                mode = data[2:0];
            else
                lfsr = (data == 16'd0) ? 16'd1 : data;
        endfunction

        function logic [15:0] lfsr_advance();
            logic fb;
            fb = lfsr[0];
            lfsr = lfsr >> 1;
            if (fb)
                lfsr = lfsr ^ LfsrTaps;
            return lfsr;
        endfunction

        function void exchange(int unsigned a, int unsigned b);
            logic signed [31:0] t;
            t = store[a];
            store[a] = store[b];
            store[b] = t;
        endfunction

        function int unsigned pick_pivot(int unsigned lo, int unsigned hi);
            int unsigned mid;
            logic signed [31:0] a, b, c;
            mid = lo + (hi - lo) / 2;
            a = store[lo];
            b = store[mid];
            c = store[hi];
            case (mode)
                PIV_LAST:   return hi;
                PIV_MIDDLE: return mid;
                PIV_RANDOM: return lo + (int'(lfsr_advance()) % (hi - lo + 1));
                PIV_MEDIAN:
                begin
                    if ((b < a) != (c < a))
                        return lo;
                    if ((a < b) != (c < b))
                        return mid;
                    return hi;
                end
                default:    return lo;
            endcase
        endfunction

        // pivot to the front, smaller elements swept forward, pivot into place
        function int unsigned partition(int unsigned lo, int unsigned hi);
            int unsigned i;
            logic signed [31:0] pv;
            exchange(lo, pick_pivot(lo, hi));
            pv = store[lo];
            i = lo + 1;
            for (int unsigned j = lo + 1; j <= hi; j++)
            begin
                compares++;
                if (store[j] < pv)
                begin
                    exchange(i, j);
                    i++;
                end
            end
            exchange(lo, i - 1);
            return i - 1;
        endfunction

        function void sort_set();
            int unsigned seg_lo [Capacity];
            int unsigned seg_hi [Capacity];
            int unsigned sp, lo, hi, p;
            sp = 0;
            if (count > 1)
            begin
                seg_lo[0] = 0;
                seg_hi[0] = count - 1;
                sp = 1;
            end
            while (sp > 0)
            begin
                sp--;
                lo = seg_lo[sp];
                hi = seg_hi[sp];
                p = partition(lo, hi);
                if (p + 1 < hi && sp < Capacity)
                begin
                    seg_lo[sp] = p + 1;
                    seg_hi[sp] = hi;
                    sp++;
                end
                if (p > lo + 1 && sp < Capacity)
                begin
                    seg_lo[sp] = lo;
                    seg_hi[sp] = p - 1;
                    sp++;
                end
            end
        endfunction

        function void note_load(in_item_t it);
            out_item_t r;
            if (count < Capacity)
            begin
                store[count] = it.value;
                count++;
            end
            else
                dropped = 1;
            if (!it.last_item)
                return;
            compares = '0;
            sort_set();
            for (int unsigned k = 0; k < count; k++)
            begin
                r.sorted_value = store[k];
                r.last_out = (k + 1 == count);
                r.comparison_count = compares;
                r.overflow = dropped;
                sorted_q.push_back(r);
            end
            count = 0;
            compares = '0;
            dropped = 0;
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            if (sorted_q.size() == 0)
            begin
                report($sformatf("unexpected result value %0d", got.sorted_value));
                return;
            end
            want = sorted_q.pop_front();
            if (got.sorted_value !== want.sorted_value)
                report($sformatf("sorted_value %0d, want %0d",
                                 got.sorted_value, want.sorted_value));
            if (got.last_out !== want.last_out)
                report($sformatf("last_out %b, want %b", got.last_out, want.last_out));
            if (got.comparison_count !== want.comparison_count)
                report($sformatf("comparison_count %0d, want %0d",
                                 got.comparison_count, want.comparison_count));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %b, want %b", got.overflow, want.overflow));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    in_item;
    logic        result_valid;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    sort_scoreboard sb;
    int unsigned    items_sent;
    int unsigned    stall_cycles;
    bit             quiet;

    quicksort_pivot_select_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task send_value(logic signed [31:0] v, logic last);
        int unsigned gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        in_item.value = v;
        in_item.last_item = last;
        do
            @(posedge clk);
        while (busy);
        sb.note_load(in_item);
        items_sent++;
    endtask

    task wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (sb.sorted_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task write_reg(cfg_index_t idx, logic [15:0] data);
        wait_idle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task send_set(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_value(rand_value(), k + 1 == n);
    endtask

    initial
    begin
        int unsigned r, n;
        sb = new();
        items_sent = 0;
        stall_cycles = 0;
        quiet = 0;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PIVOT_MODE;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single element, then zero seed falling back to one
        send_value(32'sh7fffffff, 1'b1);
        write_reg(CFG_RANDOM_SEED, 16'd0);
        // every pivot mode, unused codes included, on extreme values and zero
        for (int m = 0; m < 8; m++)
        begin
            write_reg(CFG_PIVOT_MODE, 16'(m));
            send_value(32'sh7fffffff, 1'b0);
            send_value(32'sh80000000, 1'b0);
            send_value(m[0] ? 32'sd0 : 32'sh7fffffff, 1'b1);
        end

        while (items_sent < TargetItems)
        begin
            quiet = (items_sent > TargetItems - 80);
            write_reg(CFG_PIVOT_MODE, 16'($urandom_range(0, 7)));
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_RANDOM_SEED, 16'hffff);
                1:       write_reg(CFG_RANDOM_SEED, 16'd1);
                default: write_reg(CFG_RANDOM_SEED, 16'($urandom));
            endcase
            repeat (3)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    n = Capacity;
                else if (r == 1)
                    n = $urandom_range(Capacity + 1, Capacity + 4);
                else
                    n = $urandom_range(1, 10);
                send_set(n);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (sb.sorted_q.size() != 0)
            sb.report($sformatf("%0d sorted values never arrived", sb.sorted_q.size()));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/qps_pkg.sv
hw/rtl/qps_ctrl.sv
hw/rtl/qps_datapath.sv
hw/rtl/quicksort_pivot_select_core.sv
hw/rtl/qps_checker.sv
sim/quicksort_pivot_select_core_tb.sv
